[rtl/core/hebbian_associative_memory_macros.svh]
// Assertion macros for the associative memory core
`ifndef HEBBIAN_ASSOCIATIVE_MEMORY_MACROS_SVH
`define HEBBIAN_ASSOCIATIVE_MEMORY_MACROS_SVH

`ifndef SYNTHESIS
`define HAM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HAM_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define HAM_ASSERT(label, clk, rst, prop, msg)
`define HAM_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

[rtl/core/ham_pkg.sv]
`default_nettype none

package ham_pkg;

   localparam int LEN_W = 7;

   localparam logic OP_TRAIN  = 1'b0;
   localparam logic OP_RECALL = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } ham_state_type;

endpackage

`default_nettype wire

[rtl/core/hebbian_associative_memory.sv]
// A new request is taken only in the idle state, so one transaction runs at a time.
// The weight memory is read one row per cycle and each row is updated or accumulated in the
// cycle after its read. A stalled result holds the next transaction in the finish state
// until the result is taken.
// Reset: synchronous, clears control, the row valid flags (weights read as zero) and sets
// active length to 64; no clearing pass over the memory is needed.
`default_nettype none

`include "hebbian_associative_memory_macros.svh"

module hebbian_associative_memory
   import ham_pkg::*;
#(
   parameter int PATTERN_LEN = 64,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_operation,
   input  wire logic [PATTERN_LEN-1:0] req_pattern_bits,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_done_operation,
   output logic [PATTERN_LEN-1:0]      rsp_recalled_bits,
   output logic [PATTERN_LEN-1:0]      rsp_zero_mask,
   output logic                        rsp_saturated,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [LEN_W-1:0]       csr_active_length
);

   localparam int RW    = $clog2(PATTERN_LEN);
   localparam int ROW_W = PATTERN_LEN * WEIGHT_BITS;
   localparam int AW    = WEIGHT_BITS + $clog2(PATTERN_LEN) + 1;

   localparam logic signed [WEIGHT_BITS-1:0] WMAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] WMIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   // weight memory: one row of all columns per entry
   logic [ROW_W-1:0] weight_mem [PATTERN_LEN];

   ham_state_type state_ff, state_in;

   logic [LEN_W-1:0]       active_len_ff;
   logic [LEN_W-1:0]       live_n;
   logic [PATTERN_LEN-1:0] col_mask;

   logic                   op_ff;
   logic [PATTERN_LEN-1:0] pat_ff;
   logic [RW-1:0]          row_ff, row_in;
   logic [RW-1:0]          last_row_ff;

   logic                   rd_vld_ff, rd_vld_in;
   logic [RW-1:0]          rd_row_ff;
   logic                   rd_ok_ff;
   logic [ROW_W-1:0]       rd_data_ff;
   logic [ROW_W-1:0]       row_data;

   logic [PATTERN_LEN-1:0] row_valid_ff;

   logic signed [AW-1:0]   acc_ff [PATTERN_LEN];
   logic signed [AW-1:0]   acc_in [PATTERN_LEN];
   logic [ROW_W-1:0]       wr_data;
   logic                   mem_we;
   logic                   sat_ff, sat_in;
   logic                   lane_sat_any;

   logic                   accept;
   logic                   load_rsp;

   logic                   rsp_valid_ff;
   logic                   rsp_op_ff;
   logic [PATTERN_LEN-1:0] rsp_pos_ff;
   logic [PATTERN_LEN-1:0] rsp_zer_ff;
   logic                   rsp_sat_ff;
   logic [PATTERN_LEN-1:0] pos_vec;
   logic [PATTERN_LEN-1:0] zer_vec;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_len_ff <= LEN_W'(64);
      end else if (csr_valid && csr_ready) begin
         active_len_ff <= csr_active_length;
      end
   end

   assign live_n = (active_len_ff > LEN_W'(PATTERN_LEN)) ? LEN_W'(PATTERN_LEN)
                                                         : active_len_ff;

   always_comb begin
      for (int j = 0; j < PATTERN_LEN; j++) begin
         col_mask[j] = (LEN_W'(j) < live_n);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      rd_vld_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            if (accept) begin
               state_in = (live_n == '0) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            rd_vld_in = 1'b1;
            if (row_ff == last_row_ff) begin
               state_in = ST_DRAIN;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      if (accept) begin
         op_ff       <= req_operation;
         pat_ff      <= req_pattern_bits;
         last_row_ff <= RW'(live_n - LEN_W'(1));
      end
   end

   // memory read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= weight_mem[row_ff];
      rd_row_ff  <= row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= row_valid_ff[row_ff];
      end
   end

   // a row never written reads as all-zero weights
   assign row_data = rd_ok_ff ? rd_data_ff : '0;

   // per-column lanes: saturating update for train, signed accumulate for recall
   always_comb begin
      logic signed [WEIGHT_BITS-1:0] w;
      logic signed [AW-1:0]          wx;
      logic                          inc;
      logic                          p_row;
      p_row        = pat_ff[rd_row_ff];
      wr_data      = row_data;
      lane_sat_any = 1'b0;
      for (int j = 0; j < PATTERN_LEN; j++) begin
         w   = row_data[j*WEIGHT_BITS +: WEIGHT_BITS];
         wx  = AW'(w);
         inc = ~(p_row ^ pat_ff[j]);
         acc_in[j] = p_row ? (acc_ff[j] + wx) : (acc_ff[j] - wx);
         if (col_mask[j]) begin
            if (inc && (w == WMAX)) begin
               lane_sat_any = 1'b1;
            end else if (!inc && (w == WMIN)) begin
               lane_sat_any = 1'b1;
            end else begin
               wr_data[j*WEIGHT_BITS +: WEIGHT_BITS] = inc ? (w + WEIGHT_BITS'(1))
                                                           : (w - WEIGHT_BITS'(1));
            end
         end
      end
   end

   assign mem_we = rd_vld_ff && (op_ff == OP_TRAIN);
   assign sat_in = sat_ff | (mem_we && lane_sat_any);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         weight_mem[rd_row_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_we) begin
         row_valid_ff[rd_row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sat_ff <= 1'b0;
      end else begin
         sat_ff <= sat_in;
      end
      for (int j = 0; j < PATTERN_LEN; j++) begin
         if (accept) begin
            acc_ff[j] <= '0;
         end else if (rd_vld_ff && (op_ff == OP_RECALL)) begin
            acc_ff[j] <= acc_in[j];
         end
      end
   end

   // sign of each column sum
   always_comb begin
      for (int j = 0; j < PATTERN_LEN; j++) begin
         pos_vec[j] = col_mask[j] && !acc_ff[j][AW-1] && (acc_ff[j] != '0);
         zer_vec[j] = col_mask[j] && (acc_ff[j] == '0);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_op_ff  <= op_ff;
         rsp_pos_ff <= (op_ff == OP_RECALL) ? pos_vec : '0;
         rsp_zer_ff <= (op_ff == OP_RECALL) ? zer_vec : '0;
         rsp_sat_ff <= (op_ff == OP_TRAIN) ? sat_ff : 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_done_operation = rsp_op_ff;
   assign rsp_recalled_bits  = rsp_pos_ff;
   assign rsp_zero_mask      = rsp_zer_ff;
   assign rsp_saturated      = rsp_sat_ff;

   `HAM_ASSERT_NEVER(a_drain_before_idle, clock, reset,
                     rd_vld_ff && (state_ff == ST_IDLE), "row pipeline busy while idle")
   `HAM_ASSERT(a_read_from_seq, clock, reset,
               rd_vld_ff |-> $past(state_ff == ST_READ), "row data without a read")
   `HAM_ASSERT(a_train_no_bits, clock, reset,
               (rsp_valid && (rsp_done_operation == OP_TRAIN)) |->
                  ((rsp_recalled_bits == '0) && (rsp_zero_mask == '0)),
               "train result carries recall bits")
   `HAM_ASSERT_NEVER(a_pos_zero_excl, clock, reset,
                     rsp_valid && ((rsp_recalled_bits & rsp_zero_mask) != '0),
                     "column both positive and zero")

endmodule

`default_nettype wire
